[sv/jpdt_pkg.sv]
package jpdt_pkg;

  // sequencer states: at most one multiply per state on the joint path
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VEL_ERR,
    ST_POS_ERR,
    ST_STEP,
    ST_FSQ,
    ST_SPD_LO,
    ST_SPD_HI,
    ST_POS_LO,
    ST_POS_HI,
    ST_CLAMP,
    ST_EMIT_J,
    ST_IN_MUL,
    ST_IN_ACC,
    ST_IN_EMIT
  } state_e;

  // configuration register indexes
  localparam logic [2:0] CFG_JOINT_COUNT = 3'd0;
  localparam logic [2:0] CFG_FREQUENCY   = 3'd1;
  localparam logic [2:0] CFG_PERIOD      = 3'd2;
  localparam logic [2:0] CFG_POS_GAIN    = 3'd3;
  localparam logic [2:0] CFG_VEL_GAIN    = 3'd4;
  localparam logic [2:0] CFG_MARGIN      = 3'd5;

  // command codes
  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_INERTIA = 1'b1;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  // saturate a 64 bit value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > S32_MAX) r = 32'sh7fffffff;
    else if (x < S32_MIN) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

[sv/jpdt_ram.sv]
module jpdt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [WIDTH-1:0]      wdata_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [WIDTH-1:0]      rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/joint_pd_torque_with_limits.sv]
// Joint-space PD torque controller with acceleration limits, Q16.16.
// Input channel: in_valid_i / in_stall_o, one beat is a joint sample
// (command_i = 0) or one inertia matrix entry (command_i = 1).
// Output channel: out_valid_o / out_stall_i, exactly one result beat per
// input beat, in order, held in an output register.
// A joint sample passes through the states VEL_ERR to EMIT_J before it
// reaches the output register; an inertia entry through IN_MUL, IN_ACC and
// IN_EMIT. The next beat is accepted only once the sequencer is back in
// idle. The sequence is set by the single shared 35x33 multiplier, used once per cycle.
// Stored accelerations sit in a MAX_JOINTS-entry RAM (8 by default) with a registered read; the
// inertia path reads it at the column of the accepted beat.
// Reset returns the configuration registers to their defaults and clears
// the row accumulator and the handshake state; RAM contents stay unknown
// until written. If the receiver stalls, the result stays in the output
// register and a further result waits in its last step until it drains.
// Configuration writes (cfg_we_i) take effect at once and are meant for
// idle periods.
module joint_pd_torque_with_limits #(
  parameter int MAX_JOINTS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [30:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [2:0]         row_index_i,
  input  logic [2:0]         column_index_i,
  input  logic signed [31:0] desired_position_i,
  input  logic signed [31:0] desired_velocity_i,
  input  logic signed [31:0] desired_acceleration_i,
  input  logic signed [31:0] measured_position_i,
  input  logic signed [31:0] measured_velocity_i,
  input  logic signed [31:0] lower_position_limit_i,
  input  logic signed [31:0] upper_position_limit_i,
  input  logic [30:0]        joint_speed_limit_i,
  input  logic signed [31:0] inertia_entry_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         out_index_o,
  output logic signed [31:0] clamped_acceleration_o,
  output logic signed [31:0] joint_torque_o,
  output logic               torque_ready_o,
  output logic               limits_crossed_o
);
  localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int IW = (AW > 3) ? AW : 3;

  // configuration registers
  logic [3:0]  jc_q;
  logic [13:0] f_q;
  logic [16:0] t_q;
  logic [30:0] kp_q, kv_q;
  logic [16:0] m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jc_q <= 4'd6;
      f_q  <= 14'd500;
      t_q  <= 17'd131;
      kp_q <= 31'd6553600;
      kv_q <= 31'd1310720;
      m_q  <= 17'd66;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        jpdt_pkg::CFG_JOINT_COUNT: jc_q <= cfg_data_i[3:0];
        jpdt_pkg::CFG_FREQUENCY:   f_q  <= cfg_data_i[13:0];
        jpdt_pkg::CFG_PERIOD:      t_q  <= cfg_data_i[16:0];
        jpdt_pkg::CFG_POS_GAIN:    kp_q <= cfg_data_i;
        jpdt_pkg::CFG_VEL_GAIN:    kv_q <= cfg_data_i;
        jpdt_pkg::CFG_MARGIN:      m_q  <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  jpdt_pkg::state_e state_q, state_d;

  logic in_acc, out_free;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_o || !out_stall_i;

  // captured beat
  logic [2:0]         row_q, col_q;
  logic signed [31:0] pe_q, ve_q, da_q, mp_q, mv_q, lpl_q, upl_q, e_q;
  logic [30:0]        sl_q;

  logic signed [32:0] pe_diff, ve_diff;
  assign pe_diff = {desired_position_i[31], desired_position_i}
                 - {measured_position_i[31], measured_position_i};
  assign ve_diff = {desired_velocity_i[31], desired_velocity_i}
                 - {measured_velocity_i[31], measured_velocity_i};

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      row_q <= row_index_i;
      col_q <= column_index_i;
      pe_q  <= jpdt_pkg::sat32(64'(pe_diff));
      ve_q  <= jpdt_pkg::sat32(64'(ve_diff));
      da_q  <= desired_acceleration_i;
      mp_q  <= measured_position_i;
      mv_q  <= measured_velocity_i;
      lpl_q <= lower_position_limit_i;
      upl_q <= upper_position_limit_i;
      sl_q  <= joint_speed_limit_i;
      e_q   <= inertia_entry_i;
    end
  end

  // acceleration store
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;
  logic [IW-1:0] row_ext, col_ext;
  assign row_ext   = IW'(row_q);
  assign col_ext   = IW'(column_index_i);
  assign ram_waddr = row_ext[AW-1:0];
  assign ram_raddr = col_ext[AW-1:0];

  jpdt_ram #(.WIDTH(32), .DEPTH(MAX_JOINTS)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic row_ok, col_ok;
  assign row_ok = int'(row_q) < MAX_JOINTS;
  assign col_ok = int'(col_q) < MAX_JOINTS;

  // shared multiplier
  logic signed [34:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [67:0] mul_p;
  logic signed [63:0] p_q;
  assign mul_p = mul_a * mul_b;

  // intermediates
  logic signed [48:0] asum_q;
  logic signed [31:0] a_q;
  logic signed [32:0] step_q;
  logic [28:0]        ff2_q;
  logic signed [34:0] dl_q, du_q;
  logic signed [63:0] spd_lo_q, spd_hi_q, lower_q, upper_q;
  logic signed [63:0] acc_q;

  logic signed [32:0] sl_plus, sl_minus;
  assign sl_plus  = $signed({2'b00, sl_q}) + $signed({mv_q[31], mv_q});
  assign sl_minus = $signed({2'b00, sl_q}) - $signed({mv_q[31], mv_q});

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      jpdt_pkg::ST_IDLE:
        if (in_acc) begin
          state_d = (command_i == jpdt_pkg::CMD_INERTIA) ? jpdt_pkg::ST_IN_MUL
                                                         : jpdt_pkg::ST_VEL_ERR;
        end
      jpdt_pkg::ST_VEL_ERR: state_d = jpdt_pkg::ST_POS_ERR;
      jpdt_pkg::ST_POS_ERR: state_d = jpdt_pkg::ST_STEP;
      jpdt_pkg::ST_STEP:    state_d = jpdt_pkg::ST_FSQ;
      jpdt_pkg::ST_FSQ:     state_d = jpdt_pkg::ST_SPD_LO;
      jpdt_pkg::ST_SPD_LO:  state_d = jpdt_pkg::ST_SPD_HI;
      jpdt_pkg::ST_SPD_HI:  state_d = jpdt_pkg::ST_POS_LO;
      jpdt_pkg::ST_POS_LO:  state_d = jpdt_pkg::ST_POS_HI;
      jpdt_pkg::ST_POS_HI:  state_d = jpdt_pkg::ST_CLAMP;
      jpdt_pkg::ST_CLAMP:   state_d = jpdt_pkg::ST_EMIT_J;
      jpdt_pkg::ST_EMIT_J:  if (out_free) state_d = jpdt_pkg::ST_IDLE;
      jpdt_pkg::ST_IN_MUL:  state_d = jpdt_pkg::ST_IN_ACC;
      jpdt_pkg::ST_IN_ACC:  state_d = jpdt_pkg::ST_IN_EMIT;
      jpdt_pkg::ST_IN_EMIT: if (out_free) state_d = jpdt_pkg::ST_IDLE;
      default:              state_d = jpdt_pkg::ST_IDLE;
    endcase
  end

  // clamp of the final acceleration
  logic signed [63:0] lo_m, hi_m, a64, r1, r2;
  logic signed [31:0] r_sat;
  logic               crossed;
  assign a64     = 64'(a_q);
  assign lo_m    = lower_q + $signed({47'd0, m_q});
  assign hi_m    = upper_q - $signed({47'd0, m_q});
  assign r1      = (a64 < lo_m) ? lo_m : a64;
  assign r2      = (r1 > hi_m) ? hi_m : r1;
  assign r_sat   = jpdt_pkg::sat32(r2);
  assign crossed = lower_q > upper_q;

  // saturating accumulate and torque
  logic signed [64:0] sum65;
  logic signed [63:0] acc_sum;
  logic signed [31:0] torque;
  logic               last_col;
  assign sum65    = 65'(acc_q) + 65'(p_q);
  assign acc_sum  = (sum65[64] != sum65[63]) ?
                    (sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sum65[63:0];
  assign torque   = jpdt_pkg::sat32(acc_q >>> 16);
  assign last_col = {1'b0, col_q} == (jc_q - 4'd1);

  // outputs of the sequencer
  always_comb begin
    in_stall_o = state_q != jpdt_pkg::ST_IDLE;
    ram_we     = 1'b0;
    ram_wdata  = r_sat;
    mul_a      = 35'(ve_q);
    mul_b      = $signed({2'b00, kv_q});
    case (state_q)
      jpdt_pkg::ST_VEL_ERR: begin
        mul_a = 35'(ve_q);
        mul_b = $signed({2'b00, kv_q});
      end
      jpdt_pkg::ST_POS_ERR: begin
        mul_a = 35'(pe_q);
        mul_b = $signed({2'b00, kp_q});
      end
      jpdt_pkg::ST_STEP: begin
        mul_a = 35'(mv_q);
        mul_b = $signed({16'd0, t_q});
      end
      jpdt_pkg::ST_FSQ: begin
        mul_a = $signed({21'd0, f_q});
        mul_b = $signed({19'd0, f_q});
      end
      jpdt_pkg::ST_SPD_LO: begin
        mul_a = 35'(sl_plus);
        mul_b = $signed({19'd0, f_q});
      end
      jpdt_pkg::ST_SPD_HI: begin
        mul_a = 35'(sl_minus);
        mul_b = $signed({19'd0, f_q});
      end
      jpdt_pkg::ST_POS_LO: begin
        mul_a = dl_q;
        mul_b = $signed({4'd0, ff2_q});
      end
      jpdt_pkg::ST_POS_HI: begin
        mul_a = du_q;
        mul_b = $signed({4'd0, ff2_q});
      end
      jpdt_pkg::ST_EMIT_J: begin
        ram_we = out_free && row_ok;
      end
      jpdt_pkg::ST_IN_MUL: begin
        mul_a = 35'(e_q);
        mul_b = col_ok ? 33'($signed(ram_rdata)) : '0;
      end
      default: ;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jpdt_pkg::ST_IDLE;
      acc_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == jpdt_pkg::ST_IN_EMIT || state_q == jpdt_pkg::ST_EMIT_J) && out_free) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      if (state_q == jpdt_pkg::ST_IN_ACC) acc_q <= acc_sum;
      if (state_q == jpdt_pkg::ST_IN_EMIT && out_free && last_col) acc_q <= '0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    p_q <= mul_p[63:0];
    case (state_q)
      jpdt_pkg::ST_POS_ERR: asum_q <= 49'(da_q) + 49'(p_q >>> 16);
      jpdt_pkg::ST_STEP:    asum_q <= asum_q + 49'(p_q >>> 16);
      jpdt_pkg::ST_FSQ: begin
        a_q    <= jpdt_pkg::sat32(64'(asum_q));
        step_q <= $signed(p_q[48:16]);
      end
      jpdt_pkg::ST_SPD_LO: begin
        ff2_q <= {p_q[27:0], 1'b0};
        dl_q  <= 35'(lpl_q) - 35'(mp_q) - 35'(step_q);
        du_q  <= 35'(upl_q) - 35'(mp_q) - 35'(step_q);
      end
      jpdt_pkg::ST_SPD_HI: spd_lo_q <= -p_q;
      jpdt_pkg::ST_POS_LO: spd_hi_q <= p_q;
      jpdt_pkg::ST_POS_HI: lower_q  <= (p_q > spd_lo_q) ? p_q : spd_lo_q;
      jpdt_pkg::ST_CLAMP:  upper_q  <= (p_q < spd_hi_q) ? p_q : spd_hi_q;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (state_q == jpdt_pkg::ST_EMIT_J && out_free) begin
      out_index_o            <= row_q;
      clamped_acceleration_o <= r_sat;
      joint_torque_o         <= '0;
      torque_ready_o         <= 1'b0;
      limits_crossed_o       <= crossed;
    end else if (state_q == jpdt_pkg::ST_IN_EMIT && out_free) begin
      out_index_o            <= row_q;
      clamped_acceleration_o <= '0;
      joint_torque_o         <= last_col ? torque : '0;
      torque_ready_o         <= last_col;
      limits_crossed_o       <= 1'b0;
    end
  end

endmodule

[tb/joint_pd_torque_with_limits_test.sv]
`timescale 1ns / 1ps

module joint_pd_torque_with_limits_test;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_index_i = '0;
  logic [30:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               command_i = jpdt_pkg::CMD_SAMPLE;
  logic [2:0]         row_index_i = '0;
  logic [2:0]         column_index_i = '0;
  logic signed [31:0] desired_position_i = '0;
  logic signed [31:0] desired_velocity_i = '0;
  logic signed [31:0] desired_acceleration_i = '0;
  logic signed [31:0] measured_position_i = '0;
  logic signed [31:0] measured_velocity_i = '0;
  logic signed [31:0] lower_position_limit_i = '0;
  logic signed [31:0] upper_position_limit_i = '0;
  logic [30:0]        joint_speed_limit_i = '0;
  logic signed [31:0] inertia_entry_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         out_index_o;
  logic signed [31:0] clamped_acceleration_o;
  logic signed [31:0] joint_torque_o;
  logic               torque_ready_o;
  logic               limits_crossed_o;

  typedef struct {
    logic               cmd;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] dp, dv, da, mp, mv, lpl, upl;
    logic [30:0]        sl;
    logic signed [31:0] entry;
  } beat_t;

  typedef struct {
    logic [2:0]         index;
    logic signed [31:0] accel;
    logic signed [31:0] torque;
    logic               ready;
    logic               crossed;
  } result_t;

  joint_pd_torque_with_limits dut (.*);

  // controller copy: registers, acceleration store, row sum
  logic [3:0]         jc_q;
  logic [13:0]        freq_q;
  logic [16:0]        period_q;
  logic [30:0]        kp_q, kv_q;
  logic [16:0]        margin_q;
  logic signed [31:0] accel_mem [8];
  logic signed [63:0] row_sum;

  result_t pending_results[$];
  int      mismatches = 0;
  int      idle_pct = 24;
  int      hold_left = 0;

  always #5 clk_i = ~clk_i;

  function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) s = 64'sh7fffffffffffffff;
    else if (a[63] && b[63] && !s[63]) s = 64'sh8000000000000000;
    return s;
  endfunction

  function automatic logic signed [63:0] clip32(logic signed [63:0] x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // torque controller step: updates the store or the row sum
  function automatic result_t torque_step(beat_t b);
    result_t r;
    logic signed [63:0] dp, dv, da, mp, mv, lpl, upl, sl, f, kp, kv, m;
    logic signed [63:0] pe, ve, a, stp, ff2, plo, phi, slo, shi, lo, hi, acc;
    r.index = b.row; r.accel = '0; r.torque = '0; r.ready = 1'b0; r.crossed = 1'b0;
    if (b.cmd == jpdt_pkg::CMD_SAMPLE) begin
      dp = b.dp; dv = b.dv; da = b.da; mp = b.mp; mv = b.mv; lpl = b.lpl; upl = b.upl;
      sl = {33'd0, b.sl};
      f = {50'd0, freq_q}; kp = {33'd0, kp_q}; kv = {33'd0, kv_q}; m = {47'd0, margin_q};
      pe = clip32(dp - mp);
      ve = clip32(dv - mv);
      a = clip32(da + ((kv * ve) >>> 16) + ((kp * pe) >>> 16));
      stp = (mv * $signed({47'd0, period_q})) >>> 16;
      ff2 = 2 * f * f;
      plo = ff2 * (lpl - mp - stp);
      phi = ff2 * (upl - mp - stp);
      slo = -(f * (sl + mv));
      shi = f * (sl - mv);
      lo = (plo > slo) ? plo : slo;
      hi = (phi < shi) ? phi : shi;
      if (a < lo + m) a = lo + m;
      if (a > hi - m) a = hi - m;
      a = clip32(a);
      accel_mem[b.row] = a[31:0];
      r.accel = a[31:0];
      r.crossed = lo > hi;
    end else begin
      acc = accel_mem[b.col];
      row_sum = sat_add(row_sum, 64'(b.entry) * acc);
      if ({1'b0, b.col} == jc_q - 4'd1) begin
        acc = clip32(row_sum >>> 16);
        r.torque = acc[31:0];
        r.ready = 1'b1;
        row_sum = '0;
      end
    end
    return r;
  endfunction

  function automatic logic signed [31:0] pick32();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $signed($urandom_range(524288)) - 262144;
      2: return $signed($urandom_range(33554432)) - 16777216;
      3: case ($urandom_range(3))
           0: return 32'sh7fffffff;
           1: return 32'sh80000000;
           2: return 32'sd0;
           default: return -32'sd1;
         endcase
      default: return $signed($urandom_range(8388608)) - 4194304;
    endcase
  endfunction

  function automatic beat_t make_sample(logic [2:0] row);
    beat_t b;
    b.cmd = jpdt_pkg::CMD_SAMPLE; b.row = row; b.col = 3'($urandom);
    b.dp = pick32(); b.dv = pick32(); b.da = pick32(); b.mp = pick32();
    b.mv = pick32(); b.lpl = pick32(); b.upl = pick32();
    b.sl = 31'(pick32()); b.entry = 32'($urandom);
    if ($urandom_range(1)) begin
      // keep the window open and mostly sane
      if (b.lpl > b.upl) begin
        b.lpl = b.upl;
        b.upl = pick32();
      end
    end
    return b;
  endfunction

  function automatic beat_t make_entry(logic [2:0] row, logic [2:0] col);
    beat_t b;
    b = make_sample(row);
    b.cmd = jpdt_pkg::CMD_INERTIA; b.col = col; b.entry = pick32();
    return b;
  endfunction

  task automatic report(string what, longint expv, longint gotv);
    $display("mismatch %s: expected %0d got %0d at %0t", what, expv, gotv, $realtime);
    mismatches++;
  endtask

  // send one beat, predict it on acceptance
  task automatic send_beat(beat_t b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= b.cmd; row_index_i <= b.row; column_index_i <= b.col;
    desired_position_i <= b.dp; desired_velocity_i <= b.dv;
    desired_acceleration_i <= b.da; measured_position_i <= b.mp;
    measured_velocity_i <= b.mv; lower_position_limit_i <= b.lpl;
    upper_position_limit_i <= b.upl; joint_speed_limit_i <= b.sl;
    inertia_entry_i <= b.entry;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    pending_results.push_back(torque_step(b));
  endtask

  // lower valid and wait for every result, then for the block to settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  // one register write per clock; the caller lowers the write enable
  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      jpdt_pkg::CFG_JOINT_COUNT: jc_q = val[3:0];
      jpdt_pkg::CFG_FREQUENCY:   freq_q = val[13:0];
      jpdt_pkg::CFG_PERIOD:      period_q = val[16:0];
      jpdt_pkg::CFG_POS_GAIN:    kp_q = val;
      jpdt_pkg::CFG_VEL_GAIN:    kv_q = val;
      jpdt_pkg::CFG_MARGIN:      margin_q = val[16:0];
      default: ;
    endcase
  endtask

  task automatic set_all(int jc, int f, int t, int kp, int kv, int m);
    write_reg(jpdt_pkg::CFG_JOINT_COUNT, 31'(jc));
    write_reg(jpdt_pkg::CFG_FREQUENCY, 31'(f));
    write_reg(jpdt_pkg::CFG_PERIOD, 31'(t));
    write_reg(jpdt_pkg::CFG_POS_GAIN, 31'(kp));
    write_reg(jpdt_pkg::CFG_VEL_GAIN, 31'(kv));
    write_reg(jpdt_pkg::CFG_MARGIN, 31'(m));
    cfg_we_i <= 1'b0;
  endtask

  // one inertia row, mostly in column order, now and then broken
  task automatic send_row();
    int last;
    logic [2:0] row;
    row = 3'($urandom);
    last = (jc_q >= 1 && jc_q <= 8) ? jc_q - 1 : 7;
    for (int c = 0; c <= last; c++) begin
      if ($urandom_range(19) == 0) send_beat(make_entry(row, 3'($urandom)));
      else send_beat(make_entry(row, 3'(c)));
    end
  endtask

  task automatic random_mix(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: send_beat(make_sample(3'($urandom)));
        4, 5, 6, 7: send_row();
        default: send_beat(make_entry(3'($urandom), 3'($urandom)));
      endcase
    end
  endtask

  task automatic test_directed();
    beat_t b;
    // fill every store entry first; wide window, extreme feedforward
    for (int j = 0; j < 8; j++) begin
      b = make_sample(3'(j));
      b.dp = 0; b.mp = 0; b.mv = 0; b.dv = 0;
      b.lpl = 32'sh80000000; b.upl = 32'sh7fffffff; b.sl = 31'h7fffffff;
      b.da = (j % 2) ? 32'sh80000000 : 32'sh7fffffff;
      send_beat(b);
    end
    // crossed limits
    b = make_sample(3);
    b.lpl = 32'sd65536; b.upl = -32'sd65536; b.mp = 0; b.mv = 0;
    send_beat(b);
    // extreme position and velocity errors
    b = make_sample(6);
    b.dp = 32'sh7fffffff; b.mp = 32'sh80000000;
    b.dv = 32'sh80000000; b.mv = 32'sh7fffffff; b.sl = 0;
    send_beat(b);
    b = make_sample(0);
    b.da = 32'sh7fffffff; b.dp = 0; b.mp = 0; b.dv = 0; b.mv = 0;
    b.lpl = 32'sh80000000; b.upl = 32'sh7fffffff; b.sl = 31'h7fffffff;
    send_beat(b);
    // accumulator overflow on column zero, then row end
    for (int c = 0; c < 3; c++) send_beat(make_entry(1, 0));
    for (int c = 0; c < 3; c++) begin
      b = make_entry(1, 0); b.entry = 32'sh7fffffff; send_beat(b);
    end
    for (int c = 1; c < 6; c++) send_beat(make_entry(1, 3'(c)));
    // column past the last accumulates only
    send_beat(make_entry(2, 7));
    send_beat(make_entry(2, 5));
    drain();
  endtask

  task automatic test_settings();
    set_all(1, 1, 65536, 0, 0, 0);
    random_mix(40);
    drain();
    set_all(8, 10000, 0, 32'h7fffffff, 32'h7fffffff, 65536);
    random_mix(40);
    drain();
    set_all(0, 0, 131, 6553600, 1310720, 66);
    random_mix(20);
    drain();
    set_all(15, 500, 131, 65536, 65536, 0);
    random_mix(20);
    drain();
    set_all(3, 1000, 66, 131072, 32768, 1000);
    random_mix(40);
    drain();
  endtask

  task automatic test_backpressure();
    hold_left = 400;
    idle_pct = 0;
    random_mix(80);
    idle_pct = 24;
    drain();
  endtask

  task automatic test_pause();
    random_mix(30);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    random_mix(30);
    drain();
  endtask

  task automatic test_random();
    set_all(6, 500, 131, 6553600, 1310720, 66);
    random_mix(150);
    idle_pct = 0;
    random_mix(80);
    idle_pct = 24;
    random_mix(100);
    drain();
    set_all(4, 2000, 33, 2000000, 400000, 300);
    random_mix(120);
    drain();
  endtask

  // result checking and receiver stall
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report("unexpected beat", 0, 1);
      end else begin
        if (out_index_o !== pending_results[0].index)
          report("out_index", pending_results[0].index, out_index_o);
        if (clamped_acceleration_o !== pending_results[0].accel)
          report("clamped_acceleration", pending_results[0].accel, clamped_acceleration_o);
        if (joint_torque_o !== pending_results[0].torque)
          report("joint_torque", pending_results[0].torque, joint_torque_o);
        if (torque_ready_o !== pending_results[0].ready)
          report("torque_ready", pending_results[0].ready, torque_ready_o);
        if (limits_crossed_o !== pending_results[0].crossed)
          report("limits_crossed", pending_results[0].crossed, limits_crossed_o);
        void'(pending_results.pop_front());
      end
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  initial begin
    jc_q = 6; freq_q = 500; period_q = 131; kp_q = 6553600; kv_q = 1310720;
    margin_q = 66; row_sum = '0;
    foreach (accel_mem[i]) accel_mem[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_settings();
    test_backpressure();
    test_pause();
    test_random();
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #10ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[filelist.f]
sv/jpdt_pkg.sv
sv/jpdt_ram.sv
sv/joint_pd_torque_with_limits.sv
tb/joint_pd_torque_with_limits_test.sv
